FILE: rtl/rrs_pkg.sv
package rrs_pkg;

  localparam int SLOT_ID_W = 3;
  localparam int LOCK_ID_W = 3;

  typedef logic [SLOT_ID_W-1:0] slot_id_t;
  typedef logic [LOCK_ID_W-1:0] lock_id_t;

  typedef enum logic [1:0] {
    REQ_CREATE  = 2'd0,
    REQ_SWITCH  = 2'd1,
    REQ_ACQUIRE = 2'd2,
    REQ_RELEASE = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_IDLE    = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_BLOCKED = 2'd3
  } status_t;

  typedef struct packed {
    status_t  status;
    slot_id_t slot;
    logic     woke;
  } res_t;

endpackage

FILE: rtl/round_robin_scheduler_with_mutex_queues_core.sv
// Hardware round-robin task scheduler with mutex wait queues.
// Requests enter on the in_ ports: a request is taken at a rising edge with start
// high and busy low. in_req_type selects create, switch, acquire or release;
// in_stack_pointer carries the initial or saved stack pointer (zero on switch
// means the running process ended); in_lock_id names the lock.
// Every request gives exactly one result beat on the out_ ports, shown for one
// cycle with out_valid high: status, slot, next stack pointer and a wake flag.
// Work is done by a small sequencer around slot and lock tables with registered
// reads, one write and one read per table per cycle. Acquire, a full create, a
// release with no waiter and a switch that keeps or idles the running slot end
// in the execute step; a create may add a link step, a waking release reads the
// wait-queue head and its successor, and a rotating switch may requeue the
// outgoing slot before popping the ready-queue head. Busy stays high until the
// cycle the result appears, so a new request can be taken while out_valid is high.
// A synchronous active-low reset empties the ready and wait queues, frees all
// locks and forgets all slots; tables need no clearing pass. The receiver
// cannot stall: each result beat is taken in the cycle it is shown.
module round_robin_scheduler_with_mutex_queues_core #(
  parameter int MAX_PROCS     = 8,
  parameter int NUM_LOCKS     = 8,
  parameter int POINTER_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_req_type,
  input  logic [POINTER_WIDTH-1:0]    in_stack_pointer,
  input  rrs_pkg::lock_id_t           in_lock_id,
  output logic                        out_valid,
  output logic [1:0]                  out_status,
  output rrs_pkg::slot_id_t           out_slot_id,
  output logic [POINTER_WIDTH-1:0]    out_next_pointer,
  output logic                        out_woke_one
);

  logic                     busy_r;
  logic                     out_valid_r;
  rrs_pkg::res_t            out_res_r;
  logic [POINTER_WIDTH-1:0] out_ptr_r;
  logic                     go;
  logic                     seq_done;
  rrs_pkg::res_t            seq_res;
  logic [POINTER_WIDTH-1:0] seq_ptr;

  assign go = start && !busy_r;

  rrs_seq #(
    .MAX_PROCS    (MAX_PROCS),
    .NUM_LOCKS    (NUM_LOCKS),
    .POINTER_WIDTH(POINTER_WIDTH)
  ) u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (go),
    .req    (rrs_pkg::req_t'(in_req_type)),
    .ptr    (in_stack_pointer),
    .lk     (in_lock_id),
    .done   (seq_done),
    .res    (seq_res),
    .res_ptr(seq_ptr)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= seq_done;
      if (go) begin
        busy_r <= 1'b1;
      end else if (seq_done) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (seq_done) begin
      out_res_r <= seq_res;
      out_ptr_r <= seq_ptr;
    end
  end

  assign busy             = busy_r;
  assign out_valid        = out_valid_r;
  assign out_status       = out_res_r.status;
  assign out_slot_id      = out_res_r.slot;
  assign out_next_pointer = out_ptr_r;
  assign out_woke_one     = out_res_r.woke;

endmodule

FILE: rtl/rrs_seq.sv
module rrs_seq #(
  parameter int MAX_PROCS     = 8,
  parameter int NUM_LOCKS     = 8,
  parameter int POINTER_WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     go,
  input  rrs_pkg::req_t            req,
  input  logic [POINTER_WIDTH-1:0] ptr,
  input  rrs_pkg::lock_id_t        lk,
  output logic                     done,
  output rrs_pkg::res_t            res,
  output logic [POINTER_WIDTH-1:0] res_ptr
);

  localparam int SW  = $clog2(MAX_PROCS + 1);
  localparam int PW  = $clog2(MAX_PROCS);
  localparam int LW  = $clog2(NUM_LOCKS + 1);
  localparam int LAW = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
  localparam logic [SW-1:0] NIL_SLOT = SW'(MAX_PROCS);
  localparam logic [LW-1:0] NIL_LOCK = LW'(NUM_LOCKS);

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b00_0000_0001,
    ST_EXEC  = 10'b00_0000_0010,
    ST_SWBO  = 10'b00_0000_0100,
    ST_WTAIL = 10'b00_0000_1000,
    ST_LINK  = 10'b00_0001_0000,
    ST_POPRD = 10'b00_0010_0000,
    ST_POPWR = 10'b00_0100_0000,
    ST_RELH  = 10'b00_1000_0000,
    ST_RELN  = 10'b01_0000_0000,
    ST_DONE  = 10'b10_0000_0000
  } state_t;

  function automatic logic [PW-1:0] sidx(input logic [SW-1:0] s);
    return s[PW-1:0];
  endfunction

  function automatic logic slot_ok(input logic [SW-1:0] s);
    return s < NIL_SLOT;
  endfunction

  state_t                   state_r, state_nxt;
  rrs_pkg::req_t            req_r;
  logic [POINTER_WIDTH-1:0] ptr_r;
  rrs_pkg::lock_id_t        lk_r;
  logic [SW-1:0]            head_r, head_nxt;
  logic [SW-1:0]            tail_r, tail_nxt;
  logic [SW-1:0]            running_r, running_nxt;
  logic [SW-1:0]            used_r, used_nxt;
  logic [SW-1:0]            cur_r, cur_nxt;
  logic [SW-1:0]            link_from_r, link_from_nxt;
  logic [LAW-1:0]           wlk_r, wlk_nxt;
  logic [NUM_LOCKS-1:0]     held_r, held_nxt;
  logic [NUM_LOCKS-1:0]     wne_r, wne_nxt;
  rrs_pkg::res_t            res_r, res_nxt;
  logic [POINTER_WIDTH-1:0] res_ptr_r, res_ptr_nxt;

  // Slot and lock tables, one write and one registered read per cycle each.
  logic [POINTER_WIDTH-1:0] sp_mem_r [MAX_PROCS];
  logic [SW-1:0]            ln_mem_r [MAX_PROCS];
  logic [LW-1:0]            bo_mem_r [MAX_PROCS];
  logic [SW-1:0]            wh_mem_r [NUM_LOCKS];
  logic [SW-1:0]            wt_mem_r [NUM_LOCKS];
  logic [POINTER_WIDTH-1:0] sp_rd_r;
  logic [SW-1:0]            ln_rd_r;
  logic [LW-1:0]            bo_rd_r;
  logic [SW-1:0]            wh_rd_r;
  logic [SW-1:0]            wt_rd_r;

  logic                     sp_we, ln_we, bo_we, wh_we, wt_we;
  logic [PW-1:0]            sp_wa, ln_wa, bo_wa, sp_ra, ln_ra, bo_ra;
  logic [LAW-1:0]           wh_wa, wt_wa, wh_ra, wt_ra;
  logic [POINTER_WIDTH-1:0] sp_wd;
  logic [SW-1:0]            ln_wd, wh_wd, wt_wd;
  logic [LW-1:0]            bo_wd;

  logic                     app_go;
  logic [SW-1:0]            app_slot;
  state_t                   app_then;
  logic                     live;
  logic                     lk_ok;
  logic [LAW-1:0]           lk_idx;
  logic [LAW-1:0]           bo_lk;

  assign live   = (ptr_r != '0) && slot_ok(running_r);
  assign lk_ok  = int'(lk_r) < NUM_LOCKS;
  assign lk_idx = LAW'(lk_r);
  assign bo_lk  = LAW'(bo_rd_r);

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    running_nxt   = running_r;
    used_nxt      = used_r;
    cur_nxt       = cur_r;
    link_from_nxt = link_from_r;
    wlk_nxt       = wlk_r;
    held_nxt      = held_r;
    wne_nxt       = wne_r;
    res_nxt       = res_r;
    res_ptr_nxt   = res_ptr_r;
    sp_we = 1'b0; sp_wa = '0; sp_wd = ptr_r; sp_ra = '0;
    ln_we = 1'b0; ln_wa = '0; ln_wd = NIL_SLOT; ln_ra = '0;
    bo_we = 1'b0; bo_wa = '0; bo_wd = NIL_LOCK; bo_ra = '0;
    wh_we = 1'b0; wh_wa = '0; wh_wd = cur_r; wh_ra = '0;
    wt_we = 1'b0; wt_wa = '0; wt_wd = cur_r; wt_ra = '0;
    app_go   = 1'b0;
    app_slot = cur_r;
    app_then = ST_DONE;

    case (state_r)
      ST_IDLE: begin
        if (go) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        res_nxt     = '{status: rrs_pkg::STAT_OK, slot: '0, woke: 1'b0};
        res_ptr_nxt = '0;
        state_nxt   = ST_DONE;
        case (req_r)
          rrs_pkg::REQ_CREATE: begin
            if (used_r == NIL_SLOT) begin
              res_nxt.status = rrs_pkg::STAT_FULL;
            end else begin
              used_nxt    = used_r + SW'(1);
              sp_we       = 1'b1;
              sp_wa       = sidx(used_r);
              bo_we       = 1'b1;
              bo_wa       = sidx(used_r);
              res_nxt.slot = rrs_pkg::slot_id_t'(used_r);
              app_go      = 1'b1;
              app_slot    = used_r;
              app_then    = ST_DONE;
            end
          end
          rrs_pkg::REQ_SWITCH: begin
            if (!slot_ok(head_r)) begin
              if (live) begin
                sp_we        = 1'b1;
                sp_wa        = sidx(running_r);
                res_nxt.slot = rrs_pkg::slot_id_t'(running_r);
                res_ptr_nxt  = ptr_r;
              end else begin
                running_nxt    = NIL_SLOT;
                res_nxt.status = rrs_pkg::STAT_IDLE;
              end
            end else if (live) begin
              sp_we     = 1'b1;
              sp_wa     = sidx(running_r);
              bo_ra     = sidx(running_r);
              cur_nxt   = running_r;
              state_nxt = ST_SWBO;
            end else begin
              state_nxt = ST_POPRD;
            end
          end
          rrs_pkg::REQ_ACQUIRE: begin
            if (lk_ok) begin
              if (!slot_ok(running_r)) begin
                res_nxt.status = rrs_pkg::STAT_IDLE;
              end else if (held_r[lk_idx]) begin
                bo_we          = 1'b1;
                bo_wa          = sidx(running_r);
                bo_wd          = LW'(lk_r);
                res_nxt.status = rrs_pkg::STAT_BLOCKED;
              end else begin
                held_nxt[lk_idx] = 1'b1;
                bo_we            = 1'b1;
                bo_wa            = sidx(running_r);
                res_nxt.slot     = rrs_pkg::slot_id_t'(running_r);
              end
            end
          end
          rrs_pkg::REQ_RELEASE: begin
            if (lk_ok) begin
              held_nxt[lk_idx] = 1'b0;
              if (wne_r[lk_idx]) begin
                wh_ra     = lk_idx;
                state_nxt = ST_RELH;
              end
            end
          end
          default: begin
            state_nxt = ST_DONE;
          end
        endcase
      end
      ST_SWBO: begin
        // The outgoing slot goes to its lock's wait queue when it is blocked, else to the ready queue.
        if (bo_rd_r < NIL_LOCK) begin
          wlk_nxt = bo_lk;
          ln_we   = 1'b1;
          ln_wa   = sidx(cur_r);
          if (wne_r[bo_lk]) begin
            wt_ra     = bo_lk;
            state_nxt = ST_WTAIL;
          end else begin
            wh_we          = 1'b1;
            wh_wa          = bo_lk;
            wt_we          = 1'b1;
            wt_wa          = bo_lk;
            wne_nxt[bo_lk] = 1'b1;
            state_nxt      = ST_POPRD;
          end
        end else begin
          app_go   = 1'b1;
          app_slot = cur_r;
          app_then = ST_POPRD;
        end
      end
      ST_WTAIL: begin
        ln_we     = 1'b1;
        ln_wa     = sidx(wt_rd_r);
        ln_wd     = cur_r;
        wt_we     = 1'b1;
        wt_wa     = wlk_r;
        state_nxt = ST_POPRD;
      end
      ST_LINK: begin
        ln_we     = 1'b1;
        ln_wa     = sidx(link_from_r);
        ln_wd     = cur_r;
        state_nxt = (req_r == rrs_pkg::REQ_SWITCH) ? ST_POPRD : ST_DONE;
      end
      ST_POPRD: begin
        ln_ra     = sidx(head_r);
        sp_ra     = sidx(head_r);
        state_nxt = ST_POPWR;
      end
      ST_POPWR: begin
        ln_we        = 1'b1;
        ln_wa        = sidx(head_r);
        running_nxt  = head_r;
        res_nxt.slot = rrs_pkg::slot_id_t'(head_r);
        res_ptr_nxt  = sp_rd_r;
        if (slot_ok(ln_rd_r)) begin
          head_nxt = ln_rd_r;
        end else begin
          head_nxt = NIL_SLOT;
          tail_nxt = NIL_SLOT;
        end
        state_nxt = ST_DONE;
      end
      ST_RELH: begin
        cur_nxt   = wh_rd_r;
        ln_ra     = sidx(wh_rd_r);
        state_nxt = ST_RELN;
      end
      ST_RELN: begin
        bo_we = 1'b1;
        bo_wa = sidx(cur_r);
        if (slot_ok(ln_rd_r)) begin
          wh_we = 1'b1;
          wh_wa = lk_idx;
          wh_wd = ln_rd_r;
        end else begin
          wne_nxt[lk_idx] = 1'b0;
        end
        res_nxt.slot = rrs_pkg::slot_id_t'(cur_r);
        res_nxt.woke = 1'b1;
        app_go       = 1'b1;
        app_slot     = cur_r;
        app_then     = ST_DONE;
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Ready-queue append: terminate the new entry, then link any old tail to it or make it head.
    if (app_go) begin
      ln_we    = 1'b1;
      ln_wa    = sidx(app_slot);
      ln_wd    = NIL_SLOT;
      tail_nxt = app_slot;
      if (slot_ok(tail_r)) begin
        link_from_nxt = tail_r;
        cur_nxt       = app_slot;
        state_nxt     = ST_LINK;
      end else begin
        head_nxt  = app_slot;
        state_nxt = app_then;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      head_r    <= NIL_SLOT;
      tail_r    <= NIL_SLOT;
      running_r <= NIL_SLOT;
      used_r    <= '0;
      held_r    <= '0;
      wne_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      running_r <= running_nxt;
      used_r    <= used_nxt;
      held_r    <= held_nxt;
      wne_r     <= wne_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go && (state_r == ST_IDLE)) begin
      req_r <= req;
      ptr_r <= ptr;
      lk_r  <= lk;
    end
    cur_r       <= cur_nxt;
    link_from_r <= link_from_nxt;
    wlk_r       <= wlk_nxt;
    res_r       <= res_nxt;
    res_ptr_r   <= res_ptr_nxt;
  end

  always_ff @(posedge clk) begin
    if (sp_we) begin
      sp_mem_r[sp_wa] <= sp_wd;
    end
    sp_rd_r <= sp_mem_r[sp_ra];
  end

  always_ff @(posedge clk) begin
    if (ln_we) begin
      ln_mem_r[ln_wa] <= ln_wd;
    end
    ln_rd_r <= ln_mem_r[ln_ra];
  end

  always_ff @(posedge clk) begin
    if (bo_we) begin
      bo_mem_r[bo_wa] <= bo_wd;
    end
    bo_rd_r <= bo_mem_r[bo_ra];
  end

  always_ff @(posedge clk) begin
    if (wh_we) begin
      wh_mem_r[wh_wa] <= wh_wd;
    end
    wh_rd_r <= wh_mem_r[wh_ra];
  end

  always_ff @(posedge clk) begin
    if (wt_we) begin
      wt_mem_r[wt_wa] <= wt_wd;
    end
    wt_rd_r <= wt_mem_r[wt_ra];
  end

  assign done    = (state_r == ST_DONE);
  assign res     = res_r;
  assign res_ptr = res_ptr_r;

endmodule

FILE: rtl/rrs_chk.sv
module rrs_chk #(
  parameter int POINTER_WIDTH = 16
) (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     start,
  input logic                     busy,
  input logic                     out_valid,
  input logic [1:0]               out_status,
  input rrs_pkg::slot_id_t        out_slot_id,
  input logic [POINTER_WIDTH-1:0] out_next_pointer,
  input logic                     out_woke_one
);

  // One result beat per request, so out_valid is never high in back-to-back cycles.
  a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result beat held for more than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  // Busy drops only together with the result beat of the request in flight.
  a_busy_ends_with_beat: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(busy) && $past(rst_n)) |-> out_valid)
    else $error("busy fell without a result beat");

  a_full_is_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == rrs_pkg::STAT_FULL)) |->
      ((out_slot_id == '0) && !out_woke_one && (out_next_pointer == '0)))
    else $error("table-full result carries data");

endmodule

bind round_robin_scheduler_with_mutex_queues_core rrs_chk #(
  .POINTER_WIDTH(POINTER_WIDTH)
) u_rrs_chk (.*);

FILE: test/tb_round_robin_scheduler_with_mutex_queues_core.sv
`timescale 1ns / 1ps

module tb_round_robin_scheduler_with_mutex_queues_core;

  localparam int MAX_PROCS = 8;
  localparam int NUM_LOCKS = 8;
  localparam int PTR_W = 16;
  localparam logic [3:0] NIL_SLOT = 4'(MAX_PROCS);
  localparam logic [3:0] NIL_LOCK = 4'(NUM_LOCKS);
  localparam int RANDOM_TARGET = 1900;

  typedef struct {
    rrs_pkg::req_t     req;
    logic [PTR_W-1:0]  sp;
    rrs_pkg::lock_id_t lk;
    int unsigned       idle_pct;
  } sched_req_t;

  typedef struct {
    rrs_pkg::status_t  st;
    rrs_pkg::slot_id_t slot;
    logic [PTR_W-1:0]  nptr;
    logic              woke;
  } sched_reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_req_type = 2'd0;
  logic [PTR_W-1:0] in_stack_pointer = '0;
  rrs_pkg::lock_id_t in_lock_id = '0;
  logic out_valid;
  logic [1:0] out_status;
  rrs_pkg::slot_id_t out_slot_id;
  logic [PTR_W-1:0] out_next_pointer;
  logic out_woke_one;

  sched_req_t req_q[$];
  sched_reply_t replies_due[$];
  sched_req_t cur_req;
  int n_queued;
  int n_accepted = 0;
  int errors = 0;

  // Scheduler state as the block should hold it.
  logic [PTR_W-1:0] saved_sp[MAX_PROCS];
  logic [3:0] next_link[MAX_PROCS];
  logic [3:0] waits_on[MAX_PROCS];
  logic [3:0] rdy_head, rdy_tail, run_slot;
  int n_created;
  logic held[NUM_LOCKS];
  logic [3:0] wq_head[NUM_LOCKS];
  logic [3:0] wq_tail[NUM_LOCKS];

  round_robin_scheduler_with_mutex_queues_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_req_type(in_req_type),
    .in_stack_pointer(in_stack_pointer),
    .in_lock_id(in_lock_id),
    .out_valid(out_valid),
    .out_status(out_status),
    .out_slot_id(out_slot_id),
    .out_next_pointer(out_next_pointer),
    .out_woke_one(out_woke_one)
  );

  always #6 clk = ~clk;

  task automatic clear_scheduler();
    for (int i = 0; i < MAX_PROCS; i++) begin
      saved_sp[i] = '0;
      next_link[i] = NIL_SLOT;
      waits_on[i] = NIL_LOCK;
    end
    for (int i = 0; i < NUM_LOCKS; i++) begin
      held[i] = 1'b0;
      wq_head[i] = NIL_SLOT;
      wq_tail[i] = NIL_SLOT;
    end
    rdy_head = NIL_SLOT;
    rdy_tail = NIL_SLOT;
    run_slot = NIL_SLOT;
    n_created = 0;
  endtask

  function automatic void append_ready(logic [3:0] s);
    next_link[s] = NIL_SLOT;
    if (rdy_tail < MAX_PROCS) next_link[rdy_tail] = s;
    else rdy_head = s;
    rdy_tail = s;
  endfunction

  function automatic void append_waiter(logic [3:0] lk, logic [3:0] s);
    next_link[s] = NIL_SLOT;
    if (wq_tail[lk] < MAX_PROCS && wq_head[lk] < MAX_PROCS) next_link[wq_tail[lk]] = s;
    else wq_head[lk] = s;
    wq_tail[lk] = s;
  endfunction

  function automatic sched_reply_t schedule_request(sched_req_t r);
    sched_reply_t y;
    logic [3:0] pick, cur, w, nx;
    logic live;
    y.st = rrs_pkg::STAT_OK;
    y.slot = '0;
    y.nptr = '0;
    y.woke = 1'b0;
    case (r.req)
      rrs_pkg::REQ_CREATE: begin
        if (n_created >= MAX_PROCS) begin
          y.st = rrs_pkg::STAT_FULL;
        end else begin
          saved_sp[n_created] = r.sp;
          waits_on[n_created] = NIL_LOCK;
          append_ready(4'(n_created));
          y.slot = rrs_pkg::slot_id_t'(n_created);
          n_created++;
        end
      end
      rrs_pkg::REQ_SWITCH: begin
        // A zero pointer means the running process ended, so it is not requeued.
        live = (r.sp != '0) && (run_slot < MAX_PROCS);
        if (rdy_head >= MAX_PROCS) begin
          if (live) begin
            saved_sp[run_slot] = r.sp;
            y.slot = run_slot[2:0];
            y.nptr = r.sp;
          end else begin
            run_slot = NIL_SLOT;
            y.st = rrs_pkg::STAT_IDLE;
          end
        end else begin
          if (live) begin
            cur = run_slot;
            saved_sp[cur] = r.sp;
            if (waits_on[cur] < NUM_LOCKS) append_waiter(waits_on[cur], cur);
            else append_ready(cur);
          end
          pick = rdy_head;
          rdy_head = next_link[pick];
          next_link[pick] = NIL_SLOT;
          if (rdy_head >= MAX_PROCS) begin
            rdy_head = NIL_SLOT;
            rdy_tail = NIL_SLOT;
          end
          run_slot = pick;
          y.slot = pick[2:0];
          y.nptr = saved_sp[pick];
        end
      end
      rrs_pkg::REQ_ACQUIRE: begin
        if (run_slot >= MAX_PROCS) begin
          y.st = rrs_pkg::STAT_IDLE;
        end else if (held[r.lk]) begin
          waits_on[run_slot] = 4'(r.lk);
          y.st = rrs_pkg::STAT_BLOCKED;
        end else begin
          held[r.lk] = 1'b1;
          waits_on[run_slot] = NIL_LOCK;
          y.slot = run_slot[2:0];
        end
      end
      default: begin
        w = wq_head[r.lk];
        held[r.lk] = 1'b0;
        if (w < MAX_PROCS) begin
          nx = next_link[w];
          waits_on[w] = NIL_LOCK;
          if (nx < MAX_PROCS) begin
            wq_head[r.lk] = nx;
          end else begin
            wq_head[r.lk] = NIL_SLOT;
            wq_tail[r.lk] = NIL_SLOT;
          end
          append_ready(w);
          y.slot = w[2:0];
          y.woke = 1'b1;
        end
      end
    endcase
    return y;
  endfunction

  task automatic queue_req(rrs_pkg::req_t req, logic [PTR_W-1:0] sp, int lk,
                           int unsigned pct);
    sched_req_t r;
    r.req = req;
    r.sp = sp;
    r.lk = rrs_pkg::lock_id_t'(lk);
    r.idle_pct = pct;
    req_q.push_back(r);
  endtask

  // Request driver: holds a beat until it is taken, otherwise may leave a gap.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        replies_due.push_back(schedule_request(cur_req));
        n_accepted++;
      end
      if (start && busy) begin
        // Keep the current beat on the ports.
      end else if (req_q.size() != 0 && $urandom_range(99) >= req_q[0].idle_pct) begin
        cur_req = req_q.pop_front();
        in_req_type <= cur_req.req;
        in_stack_pointer <= cur_req.sp;
        in_lock_id <= cur_req.lk;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    sched_reply_t e;
    if (rst_n && out_valid) begin
      if (replies_due.size() == 0) begin
        $display("%0t: result with nothing expected: status %0d slot %0d ptr %h woke %0b",
                 $time, out_status, out_slot_id, out_next_pointer, out_woke_one);
        errors++;
      end else begin
        e = replies_due.pop_front();
        if (out_status !== e.st || out_slot_id !== e.slot || out_next_pointer !== e.nptr
            || out_woke_one !== e.woke) begin
          $display("%0t: mismatch: expected status %0d slot %0d ptr %h woke %0b, %s",
                   $time, e.st, e.slot, e.nptr, e.woke, "got values below");
          $display("%0t:           actual   status %0d slot %0d ptr %h woke %0b",
                   $time, out_status, out_slot_id, out_next_pointer, out_woke_one);
          errors++;
        end
      end
    end
  end

  initial begin
    int pick, lk, k;
    int unsigned pct;
    clear_scheduler();

    // Directed part: idle scheduler corner cases first, then the lock paths and a full slot table.
    queue_req(rrs_pkg::REQ_SWITCH, 16'h0000, 0, 0);
    queue_req(rrs_pkg::REQ_SWITCH, 16'h1234, 0, 0);
    queue_req(rrs_pkg::REQ_ACQUIRE, 16'h0000, 0, 0);
    queue_req(rrs_pkg::REQ_RELEASE, 16'h0000, 5, 0);
    queue_req(rrs_pkg::REQ_CREATE, 16'hFFFF, 0, 0);
    queue_req(rrs_pkg::REQ_CREATE, 16'h0001, 7, 0);
    queue_req(rrs_pkg::REQ_SWITCH, 16'h0000, 0, 0);
    queue_req(rrs_pkg::REQ_ACQUIRE, 16'h0000, 7, 0);
    // The holder asks again for its own lock and is blocked.
    queue_req(rrs_pkg::REQ_ACQUIRE, 16'h0000, 7, 0);
    queue_req(rrs_pkg::REQ_SWITCH, 16'hA5A5, 0, 0);
    queue_req(rrs_pkg::REQ_ACQUIRE, 16'h0000, 7, 0);
    // Empty ready queue: a blocked process keeps running.
    queue_req(rrs_pkg::REQ_SWITCH, 16'h5A5A, 0, 0);
    queue_req(rrs_pkg::REQ_RELEASE, 16'h0000, 7, 0);
    queue_req(rrs_pkg::REQ_SWITCH, 16'h8000, 3, 0);
    queue_req(rrs_pkg::REQ_RELEASE, 16'hFFFF, 7, 0);
    for (int i = 0; i < 6; i++) queue_req(rrs_pkg::REQ_CREATE, 16'h0100 << i, i, 0);
    queue_req(rrs_pkg::REQ_CREATE, 16'h7FFF, 0, 0);
    queue_req(rrs_pkg::REQ_SWITCH, 16'h0000, 0, 0);
    queue_req(rrs_pkg::REQ_RELEASE, 16'h0000, 0, 0);

    // Random part, in four idling phases; acquire-then-switch pairs make nearly half of it.
    k = 0;
    while (k < RANDOM_TARGET) begin
      case (k * 4 / RANDOM_TARGET)
        1: pct = 58;
        3: pct = 13;
        default: pct = 0;
      endcase
      pick = $urandom_range(999);
      lk = $urandom_range(NUM_LOCKS - 1);
      if (pick < 300) begin
        queue_req(rrs_pkg::REQ_ACQUIRE, 16'($urandom), lk, pct);
        queue_req(rrs_pkg::REQ_SWITCH, 16'($urandom_range(65535, 1)), lk, pct);
        k += 2;
      end else begin
        if (pick < 500) begin
          queue_req(rrs_pkg::REQ_RELEASE, 16'($urandom), lk, pct);
        end else if (pick < 800) begin
          queue_req(rrs_pkg::REQ_SWITCH, 16'($urandom_range(65535, 1)), lk, pct);
        end else if (pick < 850) begin
          queue_req(rrs_pkg::REQ_CREATE, 16'($urandom), lk, pct);
        end else if (pick < 999) begin
          queue_req(rrs_pkg::REQ_ACQUIRE, 16'($urandom), lk, pct);
        end else begin
          queue_req(rrs_pkg::REQ_SWITCH, 16'h0000, lk, pct);
        end
        k++;
      end
    end
    n_queued = req_q.size();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    wait (n_accepted == n_queued);
    wait (replies_due.size() == 0);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #(64'd5_000_000);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: round_robin_scheduler_with_mutex_queues_core.f
rtl/rrs_pkg.sv
rtl/rrs_seq.sv
rtl/round_robin_scheduler_with_mutex_queues_core.sv
rtl/rrs_chk.sv
test/tb_round_robin_scheduler_with_mutex_queues_core.sv
